[rtl/usfa_pkg.sv]
// usfa_pkg: shared constants and types for the UART sample frame assembler.
// No dependencies; imported by usfa_core and uart_sample_frame_assembler_top.
`default_nettype none

package usfa_pkg;

  // Bytes per converter sample frame (1..8)
  localparam int FRAME_BYTES = 3;
  localparam int POS_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

  localparam int SAMPLE_W = 24;
  localparam int SAMPLE_BYTES = SAMPLE_W / 8;
  localparam int WORD_W = 32;
  localparam int BYTE_W = 8;
  localparam int CFG_IDX_W = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT        = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DISCONNECT_LIMIT = CFG_IDX_W'(1);

  localparam logic [WORD_W-1:0] GAP_LIMIT_RST        = WORD_W'(30380);
  localparam logic [WORD_W-1:0] DISCONNECT_LIMIT_RST = WORD_W'(10000000);

  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_BYTE = 1'b1
  } kind_t;

  typedef enum logic {
    EV_SAMPLE    = 1'b0,
    EV_RESET_REQ = 1'b1
  } event_t;

  typedef struct packed {
    event_t              event_res;
    logic [SAMPLE_W-1:0] sample;
    logic [WORD_W-1:0]   sample_count;
    logic                responding;
  } result_t;

endpackage

`default_nettype wire

[rtl/usfa_core.sv]
// usfa_core: frame assembly state, idle timer and result generation.
// Depends on usfa_pkg. One step per accepted beat; result is combinational.
`default_nettype none

module usfa_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          step,
  input  wire logic                          kind,
  input  wire logic [usfa_pkg::BYTE_W-1:0]   rx_byte,
  input  wire logic [usfa_pkg::WORD_W-1:0]   gap_limit,
  input  wire logic [usfa_pkg::WORD_W-1:0]   disconnect_limit,
  output logic                               res_valid,
  output usfa_pkg::result_t                  res
);
  import usfa_pkg::*;

  logic [WORD_W-1:0]   idle_ticks, idle_ticks_next, idle_inc;
  logic [POS_W-1:0]    byte_position, byte_position_next;
  logic [SAMPLE_W-1:0] partial_value, partial_value_next, merged;
  logic [WORD_W-1:0]   completed_samples, completed_samples_next;
  logic                responding_flag, responding_flag_next;
  logic                frame_done;

  always_comb begin
    // saturating idle count
    idle_inc = (idle_ticks == '1) ? idle_ticks : idle_ticks + WORD_W'(1);

    // byte lands in the lane picked by the position; lanes past the sample are lost
    merged = partial_value;
    for (int k = 0; k < SAMPLE_BYTES; k++) begin
      if (WORD_W'(byte_position) == WORD_W'(k)) begin
        merged[k*BYTE_W +: BYTE_W] = merged[k*BYTE_W +: BYTE_W] | rx_byte;
      end
    end
    frame_done = (WORD_W'(byte_position) == WORD_W'(FRAME_BYTES - 1));

    idle_ticks_next        = idle_ticks;
    byte_position_next     = byte_position;
    partial_value_next     = partial_value;
    completed_samples_next = completed_samples;
    responding_flag_next   = responding_flag;
    res_valid              = 1'b0;
    res.event_res          = EV_SAMPLE;
    res.sample             = '0;
    res.sample_count       = completed_samples;
    res.responding         = 1'b0;

    if (step) begin
      if (kind == KIND_TICK) begin
        idle_ticks_next = idle_inc;
        if (idle_inc > disconnect_limit) begin
          responding_flag_next = 1'b0;
          res_valid            = 1'b1;
          res.event_res        = EV_RESET_REQ;
        end else if (idle_inc > gap_limit && byte_position != '0) begin
          byte_position_next = '0;
          partial_value_next = '0;
        end
      end else begin
        idle_ticks_next = '0;
        if (frame_done) begin
          completed_samples_next = completed_samples + WORD_W'(1);
          responding_flag_next   = 1'b1;
          byte_position_next     = '0;
          partial_value_next     = '0;
          res_valid              = 1'b1;
          res.event_res          = EV_SAMPLE;
          res.sample             = merged;
          res.sample_count       = completed_samples_next;
          res.responding         = 1'b1;
        end else begin
          byte_position_next = byte_position + POS_W'(1);
          partial_value_next = merged;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_ticks        <= '0;
      byte_position     <= '0;
      partial_value     <= '0;
      completed_samples <= '0;
      responding_flag   <= 1'b0;
    end else begin
      idle_ticks        <= idle_ticks_next;
      byte_position     <= byte_position_next;
      partial_value     <= partial_value_next;
      completed_samples <= completed_samples_next;
      responding_flag   <= responding_flag_next;
    end
  end

endmodule

`default_nettype wire

[rtl/uart_sample_frame_assembler_top.sv]
// uart_sample_frame_assembler_top: channel handshakes, config registers, result register.
// Depends on usfa_pkg and usfa_core.
`default_nettype none

// Usage
//   Input channel (in_valid/in_ready): each beat is a timer tick (kind 0) or a
//   received UART byte (kind 1, rx_byte). Bytes build a 24-bit sample, least
//   significant byte first; FRAME_BYTES bytes complete a frame.
//   Output channel (out_valid/out_ready): a beat is a completed sample
//   (event_res 0) with the wrapping sample count, or a reset request
//   (event_res 1) on every tick once the idle count is past disconnect_limit.
//   Config channel (cfg_valid/cfg_ready, always ready): index 0 = gap_limit,
//   index 1 = disconnect_limit; other indexes are ignored.
//   Result register: a result is presented in the cycle after the beat that caused it.
//   Throughput: one input beat per cycle; the single result register is
//   refilled in the cycle it drains, so in_ready = out_ready | !out_valid.
//   Receiver stall: while out_valid is held and out_ready is low, in_ready
//   drops and no further input beat is taken; nothing is lost.
//   Reset: idle count, frame state, sample count and responding flag clear;
//   limits return to 30380 and 10000000; output register empties.
module uart_sample_frame_assembler_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            kind,
  input  wire logic [usfa_pkg::BYTE_W-1:0]     rx_byte,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 event_res,
  output logic [usfa_pkg::SAMPLE_W-1:0]        sample,
  output logic [usfa_pkg::WORD_W-1:0]          sample_count,
  output logic                                 responding,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [usfa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [usfa_pkg::WORD_W-1:0]     cfg_data
);
  import usfa_pkg::*;

  logic [WORD_W-1:0] gap_limit, disconnect_limit;
  logic              in_beat;
  logic              res_valid;
  result_t           res;
  result_t           out_reg;

  assign cfg_ready = 1'b1;
  assign in_ready  = out_ready || !out_valid;
  assign in_beat   = in_valid && in_ready;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gap_limit        <= GAP_LIMIT_RST;
      disconnect_limit <= DISCONNECT_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GAP_LIMIT:        gap_limit <= cfg_data;
        REG_DISCONNECT_LIMIT: disconnect_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  usfa_core u_core (
    .clk              (clk),
    .rst              (rst),
    .step             (in_beat),
    .kind             (kind),
    .rx_byte          (rx_byte),
    .gap_limit        (gap_limit),
    .disconnect_limit (disconnect_limit),
    .res_valid        (res_valid),
    .res              (res)
  );

  // result register: filled on a producing beat, emptied when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_beat) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat && res_valid) begin
      out_reg <= res;
    end
  end

  assign event_res    = out_reg.event_res;
  assign sample       = out_reg.sample;
  assign sample_count = out_reg.sample_count;
  assign responding   = out_reg.responding;

endmodule

`default_nettype wire

[sim/usfa_frame_checker.sv]
// usfa_frame_checker: watches the input, result and register channels of the
// sample frame assembler, predicts each result and compares it field by field.
// Depends on usfa_pkg only.
module usfa_frame_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           kind,
  input  logic [usfa_pkg::BYTE_W-1:0]    rx_byte,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic                           event_res,
  input  logic [usfa_pkg::SAMPLE_W-1:0]  sample,
  input  logic [usfa_pkg::WORD_W-1:0]    sample_count,
  input  logic                           responding,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [usfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [usfa_pkg::WORD_W-1:0]    cfg_data,
  output int unsigned                    events_outstanding,
  output int unsigned                    mismatches
);
  timeunit 1ns;
  timeprecision 1ps;
  import usfa_pkg::*;

  localparam int unsigned PRINT_CAP = 40;

  // shadow registers and frame state
  logic [WORD_W-1:0]   gap_lim;
  logic [WORD_W-1:0]   disc_lim;
  logic [WORD_W-1:0]   idle_cnt;
  logic [WORD_W-1:0]   done_cnt;
  logic [SAMPLE_W-1:0] frame_acc;
  int unsigned         frame_pos;
  logic                resp_flag;

  result_t     queued_events[$];
  int unsigned mismatch_count = 0;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // one accepted beat: tick advances the idle count, byte extends the frame
  task automatic predict_frame_step(input kind_t k, input logic [BYTE_W-1:0] b);
    result_t r;
    if (k == KIND_TICK) begin
      if (idle_cnt != '1)
        idle_cnt = idle_cnt + 1'b1;
      if (idle_cnt > disc_lim) begin
        // disconnect wins over the gap check; partial frame survives
        resp_flag = 1'b0;
        r.event_res = EV_RESET_REQ;
        r.sample = '0;
        r.sample_count = done_cnt;
        r.responding = 1'b0;
        queued_events.push_back(r);
      end else if (idle_cnt > gap_lim && frame_pos != 0) begin
        frame_pos = 0;
        frame_acc = '0;
      end
    end else begin
      idle_cnt = '0;
      frame_acc = frame_acc | SAMPLE_W'(64'(b) << (8 * (frame_pos % 8)));
      frame_pos++;
      if (frame_pos >= FRAME_BYTES) begin
        resp_flag = 1'b1;
        done_cnt = done_cnt + 1'b1;
        r.event_res = EV_SAMPLE;
        r.sample = frame_acc;
        r.sample_count = done_cnt;
        r.responding = 1'b1;
        queued_events.push_back(r);
        frame_acc = '0;
        frame_pos = 0;
      end
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      gap_lim = GAP_LIMIT_RST;
      disc_lim = DISCONNECT_LIMIT_RST;
      idle_cnt = '0;
      done_cnt = '0;
      frame_acc = '0;
      frame_pos = 0;
      resp_flag = 1'b0;
      queued_events.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_GAP_LIMIT)
          gap_lim = cfg_data;
        else if (cfg_index == REG_DISCONNECT_LIMIT)
          disc_lim = cfg_data;
      end
      if (out_valid && out_ready) begin
        if (queued_events.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing outstanding: ev %0d sample 0x%06h cnt %0d",
                                    event_res, sample, sample_count));
        end else begin
          want = queued_events.pop_front();
          if (event_res != want.event_res)
            report_mismatch($sformatf("event_res got %0d exp %0d", event_res, want.event_res));
          if (sample != want.sample)
            report_mismatch($sformatf("sample got 0x%06h exp 0x%06h", sample, want.sample));
          if (sample_count != want.sample_count)
            report_mismatch($sformatf("sample_count got %0d exp %0d",
                                      sample_count, want.sample_count));
          if (responding != want.responding)
            report_mismatch($sformatf("responding got %0d exp %0d", responding, want.responding));
        end
      end
      if (in_valid && in_ready)
        predict_frame_step(kind_t'(kind), rx_byte);
    end
    events_outstanding <= queued_events.size();
    mismatches <= mismatch_count;
  end

endmodule

[sim/uart_sample_frame_assembler_top_test.sv]
// uart_sample_frame_assembler_top_test: stimulus and verdict for the UART sample
// frame assembler; checking lives in usfa_frame_checker.
// Depends on usfa_pkg, usfa_frame_checker and uart_sample_frame_assembler_top.
module uart_sample_frame_assembler_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import usfa_pkg::*;

  localparam int unsigned LONG_HOLD      = 300;   // receiver hold-off under pressure
  localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles with no beat on any channel
  localparam int unsigned SETTLE         = 4;     // margin after the registered result

  // indexes the block must ignore
  localparam logic [CFG_IDX_W-1:0] REG_SPARE   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_TOP_IDX = '1;

  logic clk = 1'b0;
  always #2 clk = ~clk;

  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  kind_t                kind;
  logic [BYTE_W-1:0]    rx_byte;
  logic                 out_valid;
  logic                 out_ready;
  logic                 event_res;
  logic [SAMPLE_W-1:0]  sample;
  logic [WORD_W-1:0]    sample_count;
  logic                 responding;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_data;

  int unsigned events_outstanding;
  int unsigned mismatches;

  // idle controls: gaps_on and pressure_served are each used by one process only, the
  // rest are driven nonblocking so the receiver sees them race-free
  bit gaps_on = 1'b0;
  bit stalls_on;
  bit pressure_phase;
  bit pressure_served = 1'b0;
  int unsigned quiet_cycles = 0;

  uart_sample_frame_assembler_top u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_res    (event_res),
    .sample       (sample),
    .sample_count (sample_count),
    .responding   (responding),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  usfa_frame_checker u_checker (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .kind               (kind),
    .rx_byte            (rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .event_res          (event_res),
    .sample             (sample),
    .sample_count       (sample_count),
    .responding         (responding),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .events_outstanding (events_outstanding),
    .mismatches         (mismatches)
  );

  // Offer one input beat and hold it until accepted. An optional idle burst
  // goes in front; valid is never dropped between back-to-back beats.
  task automatic send_beat(input kind_t k, input logic [BYTE_W-1:0] b);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    rx_byte <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_ticks(input int unsigned n);
    repeat (n) send_beat(KIND_TICK, BYTE_W'($urandom));
  endtask

  // Register beat; valid is left high so writes can go back to back.
  // The caller lowers cfg_valid after the last one.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_limits(input logic [WORD_W-1:0] gap, input logic [WORD_W-1:0] disc);
    write_reg(REG_GAP_LIMIT, gap);
    write_reg(REG_DISCONNECT_LIMIT, disc);
    cfg_valid <= 1'b0;
  endtask

  // Stop offering, wait for every predicted result to drain, then give a
  // beat that produces no result time to finish inside the block.
  // The first edge lets the checker count a beat accepted on the last edge.
  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (events_outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Mostly whole frames with random bytes, some frames cut short, some stray
  // beats; each followed by a run of ticks that may cross the gap or
  // disconnect thresholds when those are small.
  task automatic random_phase(input int unsigned n_items, input int unsigned max_run);
    int unsigned sent;
    int unsigned pick;
    int unsigned nb;
    int unsigned run;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        nb = FRAME_BYTES;
      end else if (pick < 8) begin
        nb = $urandom_range(1, (FRAME_BYTES > 1) ? FRAME_BYTES - 1 : 1);
      end else begin
        nb = 0;
        send_beat(kind_t'($urandom_range(0, 1)), BYTE_W'($urandom));
        sent++;
      end
      repeat (nb) send_beat(KIND_BYTE, BYTE_W'($urandom));
      sent += nb;
      run = $urandom_range(0, max_run);
      send_ticks(run);
      sent += run;
    end
  endtask

  task automatic run_phase(input logic [WORD_W-1:0] gap, input logic [WORD_W-1:0] disc,
                           input int unsigned n_items, input int unsigned max_run,
                           input bit idle_mode);
    quiesce();
    set_limits(gap, disc);
    gaps_on = idle_mode;
    stalls_on <= idle_mode;
    random_phase(n_items, max_run);
  endtask

  // Receiver: random stall bursts, plus one long hold-off when the pressure
  // phase starts so the result register fills and in_ready drops.
  initial begin : receiver
    out_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (pressure_phase && !pressure_served) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        pressure_served = 1'b1;
      end else if (stalls_on && $urandom_range(0, 6) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Watchdog: a run that stops moving on every channel is a failure.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    rst <= 1'b1;
    in_valid <= 1'b0;
    kind <= KIND_TICK;
    rx_byte <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_GAP_LIMIT;
    cfg_data <= '0;
    stalls_on <= 1'b0;
    pressure_phase <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed, reset limits ---
    // byte extremes, LSB first: 0xA5FF00 then all ones
    send_beat(KIND_BYTE, 8'h00);
    send_beat(KIND_BYTE, 8'hFF);
    send_beat(KIND_BYTE, 8'hA5);
    send_beat(KIND_BYTE, 8'hFF);
    send_beat(KIND_BYTE, 8'hFF);
    send_beat(KIND_BYTE, 8'hFF);
    // ticks carry a payload the block must ignore
    send_beat(KIND_TICK, 8'hFF);
    send_beat(KIND_TICK, 8'h00);

    // gap 2, disconnect 4; writes to unused indexes afterwards must not land
    quiesce();
    write_reg(REG_GAP_LIMIT, 32'd2);
    write_reg(REG_DISCONNECT_LIMIT, 32'd4);
    write_reg(REG_SPARE, '1);
    write_reg(REG_TOP_IDX, 32'd0);
    cfg_valid <= 1'b0;
    // idle exactly at the gap limit keeps the partial frame
    send_beat(KIND_BYTE, 8'h34);
    send_ticks(2);
    send_beat(KIND_BYTE, 8'h56);
    // third tick drops the partial frame, fifth one asks for a reset
    send_ticks(5);
    send_beat(KIND_BYTE, 8'h01);
    send_beat(KIND_BYTE, 8'h02);
    send_beat(KIND_BYTE, 8'h03);

    // disconnect below the gap: reset request while a partial frame is held,
    // and the frame still completes with its first byte
    quiesce();
    set_limits(32'd10, 32'd1);
    send_beat(KIND_BYTE, 8'h77);
    send_ticks(2);
    send_beat(KIND_BYTE, 8'h88);
    send_beat(KIND_BYTE, 8'h99);

    // both limits zero: every tick is a reset request, gap never gets a say
    quiesce();
    set_limits('0, '0);
    send_ticks(1);
    send_beat(KIND_BYTE, 8'hAA);
    send_ticks(1);
    send_beat(KIND_BYTE, 8'hBB);
    send_beat(KIND_BYTE, 8'hCC);

    // --- random phases ---
    run_phase(WORD_W'($urandom_range(1, 8)), WORD_W'($urandom_range(10, 30)), 300, 34, 1'b1);
    run_phase('0, '1, 200, 5, 1'b1);
    run_phase('1, '0, 150, 6, 1'b1);
    run_phase(WORD_W'($urandom), WORD_W'($urandom), 200, 8, 1'b1);
    run_phase(WORD_W'($urandom_range(0, 15)), WORD_W'($urandom_range(15, 25)), 250, 28, 1'b0);
    run_phase(32'd20, 32'd3, 200, 24, 1'b1);

    // pressure: every tick yields a result while the receiver holds off
    quiesce();
    set_limits(WORD_W'($urandom_range(0, 4)), '0);
    gaps_on = 1'b0;
    stalls_on <= 1'b0;
    pressure_phase <= 1'b1;
    send_ticks(60);
    pressure_phase <= 1'b0;

    // last stretch runs flat out on both sides
    run_phase(WORD_W'($urandom_range(0, 10)), WORD_W'($urandom_range(5, 20)), 250, 22, 1'b0);

    quiesce();
    @(negedge clk);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
